### rtl/core/fhfa_pkg.sv
// ----------------------------------------------------------------------------
// Free-hole fit allocator package
// Shared widths, operation and status codes, sequencer states and the
// result record of the slot scan.
// ----------------------------------------------------------------------------
package fhfa_pkg;

  localparam int unsigned HoleSlots = 32;
  localparam int unsigned SlotW     = $clog2(HoleSlots);
  localparam int unsigned CntW      = SlotW + 1;
  localparam int unsigned AddrW     = 20;
  localparam int unsigned LenW      = AddrW + 1;

  typedef enum logic [1:0] {
    FuncLoad    = 2'd0,
    FuncAlloc   = 2'd1,
    FuncRelease = 2'd2,
    FuncNone    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StNoFit = 2'd1,
    StFull  = 2'd2,
    StRsvd  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PolFirst = 2'd0,
    PolBest  = 2'd1,
    PolWorst = 2'd2,
    PolNone  = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SCommit
  } state_e;

  // What one pass over the hole table has found.
  typedef struct packed {
    logic             best_found;
    logic [SlotW-1:0] best_idx;
    logic [AddrW-1:0] best_start;
    logic [LenW-1:0]  best_len;
    logic             free_found;
    logic [SlotW-1:0] free_idx;
    logic             left_found;
    logic [SlotW-1:0] left_idx;
    logic [LenW-1:0]  left_len;
    logic             right_found;
    logic [SlotW-1:0] right_idx;
    logic [LenW-1:0]  right_len;
  } scan_res_t;

endpackage

### rtl/core/fhfa_eval.sv
// ----------------------------------------------------------------------------
// Slot evaluator
// Compares one hole slot per cycle, while enabled, against the running
// fit choice, the first free slot and the release neighbors, and keeps the results.
// ----------------------------------------------------------------------------
module fhfa_eval (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic                         en_i,
  input  logic [1:0]                   policy_i,
  input  logic [fhfa_pkg::LenW-1:0]    req_i,
  input  logic [fhfa_pkg::AddrW-1:0]   base_i,
  input  logic [fhfa_pkg::AddrW-1:0]   limit_i,
  input  logic [fhfa_pkg::SlotW-1:0]   idx_i,
  input  logic                         slot_valid_i,
  input  logic [fhfa_pkg::AddrW-1:0]   slot_start_i,
  input  logic [fhfa_pkg::LenW-1:0]    slot_len_i,
  output fhfa_pkg::scan_res_t          res_o
);

  fhfa_pkg::scan_res_t res_q, res_d;
  logic [fhfa_pkg::LenW:0]   end_sum;
  logic [fhfa_pkg::AddrW:0]  limit_next;
  logic                      better;
  logic                      fits;

  // Preference of the current slot over the held choice.
  always_comb begin
    better = slot_start_i < res_q.best_start;
    if (policy_i == fhfa_pkg::PolBest && slot_len_i != res_q.best_len) begin
      better = slot_len_i < res_q.best_len;
    end else if (policy_i == fhfa_pkg::PolWorst && slot_len_i != res_q.best_len) begin
      better = slot_len_i > res_q.best_len;
    end
  end

  assign fits       = slot_valid_i && (slot_len_i >= req_i);
  assign end_sum    = {2'b00, slot_start_i} + {1'b0, slot_len_i};
  assign limit_next = {1'b0, limit_i} + {{fhfa_pkg::AddrW{1'b0}}, 1'b1};

  // Update of the held results for this slot.
  always_comb begin
    res_d = res_q;
    if (fits && (!res_q.best_found || better)) begin
      res_d.best_found = 1'b1;
      res_d.best_idx   = idx_i;
      res_d.best_start = slot_start_i;
      res_d.best_len   = slot_len_i;
    end
    if (!slot_valid_i && !res_q.free_found) begin
      res_d.free_found = 1'b1;
      res_d.free_idx   = idx_i;
    end
    if (slot_valid_i && !res_q.left_found && end_sum == {2'b00, base_i}) begin
      res_d.left_found = 1'b1;
      res_d.left_idx   = idx_i;
      res_d.left_len   = slot_len_i;
    end
    if (slot_valid_i && !res_q.right_found && {1'b0, slot_start_i} == limit_next) begin
      res_d.right_found = 1'b1;
      res_d.right_idx   = idx_i;
      res_d.right_len   = slot_len_i;
    end
  end

  // Found flags are control state; the rest is payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (clear_i) begin
      res_q.best_found  <= 1'b0;
      res_q.free_found  <= 1'b0;
      res_q.left_found  <= 1'b0;
      res_q.right_found <= 1'b0;
    end else if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/core/free_hole_fit_allocator.sv
// ----------------------------------------------------------------------------
// Free-hole fit allocator
// Hole table with load, first/best/worst fit allocate and release that coalesces in dynamic mode.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid_i/in_stall_o func, request_size, region_base/limit
//  output    out        out_valid_o/out_stall_i status, alloc_base, alloc_limit
//  config    in         APB psel/penable      fit_policy (0x0), dynamic_mode (0x4)
//
// Every transaction is accepted, then sweeps the 32 hole slots through the
// single-port table read and the slot evaluator, then commits. The block
// stalls its input for the whole sweep and commit.
// Reset clears the valid bits and the control state; table contents are not
// cleared. A stalled output holds the commit until the result register frees.
module free_hole_fit_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [20:0] request_size_i,
  input  logic [19:0] region_base_i,
  input  logic [19:0] region_limit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [19:0] alloc_base_o,
  output logic [19:0] alloc_limit_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SlotW = fhfa_pkg::SlotW;
  localparam int unsigned AddrW = fhfa_pkg::AddrW;
  localparam int unsigned LenW  = fhfa_pkg::LenW;
  localparam int unsigned CntW  = fhfa_pkg::CntW;

  fhfa_pkg::state_e state_q, state_d;

  logic [1:0]       policy_q;
  logic             dyn_q;
  logic [1:0]       func_q;
  logic [LenW-1:0]  req_q;
  logic [AddrW-1:0] base_q;
  logic [AddrW-1:0] limit_q;
  logic [CntW-1:0]  cnt_q;
  logic [fhfa_pkg::HoleSlots-1:0] valid_q;

  logic [AddrW-1:0] start_mem [fhfa_pkg::HoleSlots];
  logic [LenW-1:0]  len_mem [fhfa_pkg::HoleSlots];
  logic [AddrW-1:0] rd_start_q;
  logic [LenW-1:0]  rd_len_q;

  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [AddrW-1:0] gbase_q;
  logic [AddrW-1:0] glimit_q;

  logic             accept;
  logic             eval_en;
  logic             commit_go;
  logic             out_free;
  logic [SlotW-1:0] eval_idx;
  fhfa_pkg::scan_res_t res;

  logic             wr_en;
  logic [SlotW-1:0] wr_idx;
  logic [AddrW-1:0] wr_start;
  logic [LenW-1:0]  wr_len;
  logic             set_valid;
  logic             clr_valid;
  logic [SlotW-1:0] clr_idx;
  logic [1:0]       cm_status;
  logic [AddrW-1:0] cm_gbase;
  logic [AddrW-1:0] cm_glimit;
  logic [LenW-1:0]  rel_size;
  logic [LenW+1:0]  merge_sum;
  logic [LenW:0]    right_sum;
  logic [LenW:0]    tail_end;
  logic [LenW:0]    full_end;
  logic [LenW:0]    left_start;

  // Configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= fhfa_pkg::PolFirst;
      dyn_q    <= 1'b1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        dyn_q <= pwdata[0];
      end else begin
        policy_q <= pwdata[1:0];
      end
    end
  end
  assign prdata = paddr[2] ? {31'd0, dyn_q} : {30'd0, policy_q};

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fhfa_pkg::SIdle: begin
        if (in_valid_i) state_d = fhfa_pkg::SScan;
      end
      fhfa_pkg::SScan: begin
        if (cnt_q == CntW'(fhfa_pkg::HoleSlots)) state_d = fhfa_pkg::SCommit;
      end
      fhfa_pkg::SCommit: begin
        if (out_free) state_d = fhfa_pkg::SIdle;
      end
      default: state_d = fhfa_pkg::SIdle;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    in_stall_o = 1'b1;
    eval_en    = 1'b0;
    commit_go  = 1'b0;
    case (state_q)
      fhfa_pkg::SIdle:   in_stall_o = 1'b0;
      fhfa_pkg::SScan:   eval_en    = (cnt_q != '0);
      fhfa_pkg::SCommit: commit_go  = out_free;
      default:           in_stall_o = 1'b1;
    endcase
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign eval_idx = cnt_q[SlotW-1:0] - SlotW'(1);

  // Sequencer state, sweep counter and captured transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fhfa_pkg::SIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == fhfa_pkg::SScan) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      req_q   <= request_size_i;
      base_q  <= region_base_i;
      limit_q <= region_limit_i;
    end
  end

  // Hole table: one write port, one registered read port swept by the counter.
  always_ff @(posedge clk_i) begin
    if (commit_go && wr_en) begin
      start_mem[wr_idx] <= wr_start;
      len_mem[wr_idx]   <= wr_len;
    end
    rd_start_q <= start_mem[cnt_q[SlotW-1:0]];
    rd_len_q   <= len_mem[cnt_q[SlotW-1:0]];
  end

  fhfa_eval u_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (accept),
    .en_i         (eval_en),
    .policy_i     (policy_q),
    .req_i        (req_q),
    .base_i       (base_q),
    .limit_i      (limit_q),
    .idx_i        (eval_idx),
    .slot_valid_i (valid_q[eval_idx]),
    .slot_start_i (rd_start_q),
    .slot_len_i   (rd_len_q),
    .res_o        (res)
  );

  // Commit arithmetic of the allocate and release operations.
  assign rel_size  = {1'b0, limit_q} - {1'b0, base_q} + LenW'(1);
  assign merge_sum = {2'b00, res.left_len} + {2'b00, rel_size}
                   + (res.right_found ? {2'b00, res.right_len} : '0);
  assign right_sum = {1'b0, res.right_len} + {1'b0, rel_size};
  assign tail_end  = {2'b00, res.best_start} + {1'b0, req_q};
  assign full_end  = {2'b00, res.best_start} + {1'b0, res.best_len};
  // The left neighbor ends exactly at the base, so its start is base minus length.
  assign left_start = {2'b00, base_q} - {1'b0, res.left_len};

  // Table update and result of the transaction.
  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = res.free_idx;
    wr_start  = base_q;
    wr_len    = req_q;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    clr_idx   = res.best_idx;
    cm_status = fhfa_pkg::StOk;
    cm_gbase  = '0;
    cm_glimit = '0;
    case (func_q)
      fhfa_pkg::FuncLoad: begin
        if (req_q != '0) begin
          if (res.free_found) begin
            wr_en     = 1'b1;
            set_valid = 1'b1;
          end else begin
            cm_status = fhfa_pkg::StFull;
          end
        end
      end
      fhfa_pkg::FuncAlloc: begin
        if (req_q == '0 || policy_q == fhfa_pkg::PolNone || !res.best_found) begin
          cm_status = fhfa_pkg::StNoFit;
        end else begin
          cm_gbase = res.best_start;
          if (dyn_q && res.best_len > req_q) begin
            cm_glimit = tail_end[AddrW-1:0] - AddrW'(1);
            wr_en     = 1'b1;
            wr_idx    = res.best_idx;
            wr_start  = tail_end[AddrW-1:0];
            wr_len    = res.best_len - req_q;
          end else begin
            cm_glimit = full_end[AddrW-1:0] - AddrW'(1);
            clr_valid = 1'b1;
          end
        end
      end
      fhfa_pkg::FuncRelease: begin
        if (limit_q >= base_q) begin
          wr_len = rel_size;
          if (dyn_q && res.left_found) begin
            // Grow the left neighbor, absorbing the right one if present.
            wr_en    = 1'b1;
            wr_idx   = res.left_idx;
            wr_start = left_start[AddrW-1:0];
            wr_len   = (merge_sum[LenW+1:LenW] != 2'b00) ? '1 : merge_sum[LenW-1:0];
            clr_valid = res.right_found;
            clr_idx   = res.right_idx;
          end else if (dyn_q && res.right_found) begin
            wr_en    = 1'b1;
            wr_idx   = res.right_idx;
            wr_len   = right_sum[LenW] ? '1 : right_sum[LenW-1:0];
          end else if (res.free_found) begin
            wr_en     = 1'b1;
            set_valid = 1'b1;
          end else begin
            cm_status = fhfa_pkg::StFull;
          end
        end
      end
      default: cm_status = fhfa_pkg::StOk;
    endcase
  end

  // Valid bits of the hole slots.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (commit_go) begin
      if (set_valid) valid_q[wr_idx]  <= 1'b1;
      if (clr_valid) valid_q[clr_idx] <= 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      status_q <= cm_status;
      gbase_q  <= cm_gbase;
      glimit_q <= cm_glimit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign alloc_base_o  = gbase_q;
  assign alloc_limit_o = glimit_q;

`ifndef SYNTHESIS
  // A new result appears only out of the commit step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == fhfa_pkg::SCommit)
    else $error("result raised outside commit");

  // An accepted transaction always starts a sweep at slot zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == fhfa_pkg::SScan) && (cnt_q == '0))
    else $error("sweep did not start after accept");

  // Only a successful grant carries addresses.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != fhfa_pkg::StOk) |-> (gbase_q == '0) && (glimit_q == '0))
    else $error("failed request carries addresses");
`endif

endmodule
